/* rtl/odps_pkg.sv */
// Shared types and constants for the octave delay-line pitch shifter.
// No dependencies; every other file imports this package.
package odps_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int DEPTH_W    = 15;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 15;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 15'd16000;

    typedef enum logic [1:0] {
        MODE_DOWN   = 2'd0,
        MODE_UNISON = 2'd1,
        MODE_UP     = 2'd2,
        MODE_HOLD   = 2'd3
    } octave_mode_t;

    localparam octave_mode_t MODE_RESET = MODE_UNISON;

    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_DEPTH = 8'd1;

    typedef struct packed {
        octave_mode_t       mode;
        logic [DEPTH_W-1:0] depth;
    } cfg_t;

endpackage

/* rtl/odps_if.sv */
// Handshake channel interfaces: sample input, result output, register writes.
// Depends on odps_pkg.
interface odps_in_if import odps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface odps_out_if import odps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

interface odps_cfg_if import odps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/odps_cfg.sv */
// Configuration registers: octave mode and delay depth.
// Depends on odps_pkg.
module odps_cfg
    import odps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    octave_mode_t       mode_reg;
    logic [DEPTH_W-1:0] depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            depth_reg <= DEPTH_RESET;
        end
        else if (wr_en)
        begin
            // drop writes to unknown indexes
            unique case (wr_index)
                REG_OCTAVE_MODE: mode_reg  <= octave_mode_t'(wr_data[1:0]);
                REG_DELAY_DEPTH: depth_reg <= wr_data[DEPTH_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.mode  = mode_reg;
    assign cfg.depth = depth_reg;

endmodule

/* rtl/odps_pos.sv */
// Write and read position counters with the half-rate phase.
// Depends on odps_pkg.
module odps_pos
    import odps_pkg::*;
#(
    parameter int STORE_DEPTH = 16384,
    parameter int AW          = $clog2(STORE_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          advance,
    output logic [AW-1:0] wr_pos,
    output logic [AW-1:0] rd_pos
);

    localparam logic [AW:0]        DEPTH_MAX   = (AW+1)'(STORE_DEPTH);
    localparam logic [DEPTH_W+AW:0] DEPTH_MAX_W = (DEPTH_W+AW+1)'(STORE_DEPTH);

    logic [AW-1:0] wr_pos_reg, wr_pos_next;
    logic [AW-1:0] rd_pos_reg, rd_pos_next;
    logic          phase_reg, phase_next;
    logic [AW:0]   depth_eff;
    logic [AW:0]   wr_inc;
    logic [AW:0]   rd_inc;
    logic [1:0]    step;

    // clamp depth to one..store size
    always_comb
    begin
        if (cfg.depth == '0)
            depth_eff = (AW+1)'(1);
        else if ((DEPTH_W+AW+1)'(cfg.depth) > DEPTH_MAX_W)
            depth_eff = DEPTH_MAX;
        else
            depth_eff = (AW+1)'(cfg.depth);
    end

    always_comb
    begin
        step       = 2'd0;
        phase_next = phase_reg;
        case (cfg.mode)
            MODE_UP:     step = 2'd2;
            MODE_UNISON: step = 2'd1;
            MODE_DOWN:
            begin
                step       = {1'b0, phase_reg};
                phase_next = !phase_reg;
            end
            default:     step = 2'd0;
        endcase

        wr_inc = {1'b0, wr_pos_reg} + (AW+1)'(1);
        rd_inc = {1'b0, rd_pos_reg} + (AW+1)'(step);

        // reach or pass returns to zero, never wraps modulo
        wr_pos_next = (wr_inc >= depth_eff) ? '0 : wr_inc[AW-1:0];
        rd_pos_next = (rd_inc >= depth_eff) ? '0 : rd_inc[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
            phase_reg  <= 1'b0;
        end
        else if (advance)
        begin
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
            phase_reg  <= phase_next;
        end
    end

    assign wr_pos = wr_pos_reg;
    assign rd_pos = rd_pos_reg;

endmodule

/* rtl/odps_store.sv */
// Delay store: one write and one registered read per word, fill count for the
// zero reset contents, and bypass of a same-address write. Depends on odps_pkg.
module odps_store
    import odps_pkg::*;
#(
    parameter int STORE_DEPTH = 16384,
    parameter int AW          = $clog2(STORE_DEPTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                access,
    input  logic [AW-1:0]       wr_pos,
    input  logic [AW-1:0]       rd_pos,
    input  logic [SAMPLE_W-1:0] wr_sample,
    output logic [SAMPLE_W-1:0] rd_sample
);

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] byp_data_reg;
    logic                byp_reg;
    logic                hit_reg;
    logic [AW:0]         fill_reg;

    always_ff @(posedge clk)
    begin
        if (access)
        begin
            mem[wr_pos]  <= wr_sample;
            rd_data_reg  <= mem[rd_pos];
            byp_data_reg <= wr_sample;
            byp_reg      <= (rd_pos == wr_pos);
            hit_reg      <= ({1'b0, rd_pos} < fill_reg);
        end
    end

    // written entries always form a prefix from zero, so one count suffices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (access && ({1'b0, wr_pos} == fill_reg))
            fill_reg <= fill_reg + (AW+1)'(1);
    end

    always_comb
    begin
        if (byp_reg)
            rd_sample = byp_data_reg;
        else if (hit_reg)
            rd_sample = rd_data_reg;
        else
            rd_sample = '0;
    end

endmodule

/* rtl/octave_delay_line_pitch_shift_core.sv */
// Octave delay-line pitch shifter, top level.
// Depends on odps_pkg, odps_if, odps_cfg, odps_pos and odps_store.
//
// Takes one sample word per clock while the result channel is not stalled, and
// returns one result word per sample, in order, through the synchronous read
// of the single-write, single-read delay store and then the output register.
// Throughput is one word a cycle while the receiver is ready, set by the
// store's one write port and one read port, each used once per sample. Store
// contents read as zero until written; a fill count tracks this, so there is
// no clearing pass after reset. Register writes are always taken and apply to
// the next sample; write them only while no sample is in flight.
module octave_delay_line_pitch_shift_core
    import odps_pkg::*;
#(
    parameter int STORE_DEPTH = 16384
)
(
    input  logic       clk,
    input  logic       rst_n,
    odps_in_if.sink    sample_ch,
    odps_out_if.source result_ch,
    odps_cfg_if.sink   cfg_ch
);

    localparam int AW = $clog2(STORE_DEPTH);

    cfg_t                cfg;
    logic [AW-1:0]       wr_pos;
    logic [AW-1:0]       rd_pos;
    logic [SAMPLE_W-1:0] rd_sample;
    logic                accept;
    logic                rd_move;
    logic                rd_valid_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;

    assign cfg_ch.ready = 1'b1;

    odps_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_ch.valid),
        .wr_index (cfg_ch.index),
        .wr_data  (cfg_ch.data),
        .cfg      (cfg)
    );

    odps_pos #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (accept),
        .wr_pos  (wr_pos),
        .rd_pos  (rd_pos)
    );

    odps_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .access    (accept),
        .wr_pos    (wr_pos),
        .rd_pos    (rd_pos),
        .wr_sample (sample_ch.sample),
        .rd_sample (rd_sample)
    );

    // read stage holds its word until the output register frees up
    assign rd_move         = rd_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !rd_valid_reg || rd_move;
    assign accept          = sample_ch.valid && sample_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                rd_valid_reg <= 1'b1;
            else if (rd_move)
                rd_valid_reg <= 1'b0;

            if (rd_move)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_move)
            out_sample_reg <= rd_sample;
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.out_sample = out_sample_reg;

endmodule

/* test/tb_octave_delay_line_pitch_shift_core.sv */
// Self-checking testbench for octave_delay_line_pitch_shift_core.
// Directed table, then random register phases and samples against a behavioural predictor.
// Depends on odps_pkg, odps_if and the core itself.
`timescale 1ns / 1ps

module tb_octave_delay_line_pitch_shift_core;
    import odps_pkg::*;

    localparam int STORE_DEPTH    = 16384;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int CFG_SETTLE     = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 36;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

    typedef enum bit {
        ROW_SAMPLE,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   smp;
        bit                    typed;
        logic [SAMPLE_W-1:0]   want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;

    odps_in_if  sample_ch ();
    odps_out_if result_ch ();
    odps_cfg_if cfg_ch ();

    octave_delay_line_pitch_shift_core #(
        .STORE_DEPTH (STORE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    always #10 clk = ~clk;

    // Predictor state
    logic [SAMPLE_W-1:0] delay_mem [STORE_DEPTH];
    int                  wr_pos;
    int                  rd_pos;
    bit                  half_phase;
    octave_mode_t        model_mode;
    logic [DEPTH_W-1:0]  model_depth;

    logic [SAMPLE_W-1:0] expected_out [$];
    int                  mismatches = 0;
    int                  quiet_cycles = 0;

    bit                  stall_free = 1'b0;
    logic [15:0]         stall_pat = 16'hFFFF;
    logic [6:0]          pat_age = '0;

    row_t directed_steps [DIRECTED_ROWS];

    function automatic logic [SAMPLE_W-1:0] pitch_shift(input logic [SAMPLE_W-1:0] smp);
        int                  span;
        int                  rd;
        logic [SAMPLE_W-1:0] tap;
        span = int'(model_depth);
        if (span < 1)
            span = 1;
        if (span > STORE_DEPTH)
            span = STORE_DEPTH;
        if (wr_pos >= STORE_DEPTH)
            wr_pos = 0;
        if (rd_pos >= STORE_DEPTH)
            rd_pos = 0;
        delay_mem[wr_pos] = smp;
        wr_pos = wr_pos + 1;
        if (wr_pos >= span)
            wr_pos = 0;
        // read after the write, so equal positions forward the new sample
        rd  = rd_pos;
        tap = delay_mem[rd];
        case (model_mode)
            MODE_UP:     rd = rd + 2;
            MODE_UNISON: rd = rd + 1;
            MODE_DOWN:
            begin
                if (half_phase)
                begin
                    rd         = rd + 1;
                    half_phase = 1'b0;
                end
                else
                begin
                    half_phase = 1'b1;
                end
            end
            default: ;
        endcase
        // drop to zero rather than wrap
        if (rd >= span)
            rd = 0;
        rd_pos = rd;
        return tap;
    endfunction

    task automatic drain_results();
        while (expected_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        sample_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                               input logic [SAMPLE_W-1:0] want);
        logic [SAMPLE_W-1:0] guess;
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= smp;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        guess = pitch_shift(smp);
        expected_out.push_back(typed ? want : guess);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        // hold the sender until the pipe is empty
        sample_ch.valid <= 1'b0;
        drain_results();
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_OCTAVE_MODE)
            model_mode = octave_mode_t'(data[1:0]);
        else if (idx == REG_DELAY_DEPTH)
            model_depth = data;
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
        begin
            if (expected_out.size() == 0)
            begin
                $error("out_sample: expected none, got %0d", result_ch.out_sample);
                mismatches++;
            end
            else
            begin
                if (result_ch.out_sample !== expected_out[0])
                begin
                    $error("out_sample: expected %0d, got %0d", expected_out[0],
                           result_ch.out_sample);
                    mismatches++;
                end
                void'(expected_out.pop_front());
            end
        end
    end

    // Receiver stalls on a rotating pattern, reloaded now and then
    always @(posedge clk)
    begin
        if (stall_free)
            result_ch.ready <= 1'b1;
        else
            result_ch.ready <= stall_pat[0];
        if (pat_age == '0)
            stall_pat <= 16'($urandom_range(1, 65535));
        else
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
        pat_age <= pat_age + 7'd1;
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int                    sent;
        int                    n_items;
        int                    burst;
        int                    k;
        bit                    quiet;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   smp;
        octave_mode_t          pick;
        int                    r;

        rst_n            <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;

        foreach (delay_mem[i])
            delay_mem[i] = '0;
        wr_pos      = 0;
        rd_pos      = 0;
        half_phase  = 1'b0;
        model_mode  = MODE_RESET;
        model_depth = DEPTH_RESET;

        directed_steps = '{
            // unison after reset: both positions agree, so each word is forwarded
            '{ROW_SAMPLE, '0, '0, 10'h3FF, 1'b1, 10'h3FF},
            '{ROW_SAMPLE, '0, '0, 10'h000, 1'b1, 10'h000},
            '{ROW_SAMPLE, '0, '0, 10'h2AA, 1'b1, 10'h2AA},
            '{ROW_SAMPLE, '0, '0, 10'h155, 1'b1, 10'h155},
            // depth zero behaves as one
            '{ROW_REG, REG_DELAY_DEPTH, 15'd0, '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h3FF, 1'b1, 10'h3FF},
            '{ROW_SAMPLE, '0, '0, 10'h001, 1'b1, 10'h001},
            '{ROW_REG, REG_DELAY_DEPTH, 15'd1, '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h200, 1'b1, 10'h200},
            // oversized mode value keeps its low bits: read position holds
            '{ROW_REG, REG_OCTAVE_MODE, 15'h7FFF, '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h000, 1'b1, 10'h000},
            // unknown register must not touch the depth
            '{ROW_REG, REG_UNUSED, 15'd2, '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h111, 1'b1, 10'h111},
            '{ROW_SAMPLE, '0, '0, 10'h222, 1'b1, 10'h222},
            // depth above the store saturates
            '{ROW_REG, REG_DELAY_DEPTH, 15'h7FFF, '0, 1'b0, '0},
            '{ROW_REG, REG_OCTAVE_MODE, 15'(MODE_UP), '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h3FF, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h000, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h155, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h2AA, 1'b0, '0},
            '{ROW_REG, REG_DELAY_DEPTH, 15'd3, '0, 1'b0, '0},
            '{ROW_REG, REG_OCTAVE_MODE, 15'(MODE_DOWN), '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h011, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h022, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h033, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h044, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h055, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h066, 1'b0, '0},
            '{ROW_REG, REG_DELAY_DEPTH, 15'd16384, '0, 1'b0, '0},
            '{ROW_REG, REG_OCTAVE_MODE, 15'(MODE_UNISON), '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h0F0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h30F, 1'b0, '0},
            // shrink below the live positions
            '{ROW_REG, REG_DELAY_DEPTH, 15'd2, '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h1C3, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h23C, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 10'h3A5, 1'b0, '0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_REG)
                write_reg(directed_steps[i].idx, directed_steps[i].data);
            else
                push_sample(directed_steps[i].smp, directed_steps[i].typed,
                            directed_steps[i].want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                r = $urandom_range(0, 9);
                if (r < 3)
                    pick = MODE_DOWN;
                else if (r < 6)
                    pick = MODE_UNISON;
                else if (r < 9)
                    pick = MODE_UP;
                else
                    pick = MODE_HOLD;
                data      = CFG_DATA_W'($urandom_range(0, 32767));
                data[1:0] = pick;
                write_reg(REG_OCTAVE_MODE, data);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: data = CFG_DATA_W'($urandom_range(2, 24));
                    6:                data = CFG_DATA_W'($urandom_range(25, 300));
                    7:
                    begin
                        case ($urandom_range(0, 6))
                            0:       data = 15'd0;
                            1:       data = 15'd1;
                            2:       data = 15'd2;
                            3:       data = 15'd16383;
                            4:       data = 15'd16384;
                            5:       data = 15'd16385;
                            default: data = 15'h7FFF;
                        endcase
                    end
                    8:       data = CFG_DATA_W'($urandom_range(0, 32767));
                    default: data = CFG_DATA_W'($urandom_range(16000, 16384));
                endcase
                write_reg(REG_DELAY_DEPTH, data);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 255)),
                          CFG_DATA_W'($urandom_range(0, 32767)));

            n_items = $urandom_range(10, 120);
            quiet   = ($urandom_range(0, 3) == 0);
            stall_free <= quiet;
            burst   = $urandom_range(1, 20);
            for (k = 0; k < n_items; k++)
            begin
                if (!quiet && burst == 0)
                begin
                    pause_sender($urandom_range(1, 8));
                    burst = $urandom_range(1, 20);
                end
                if ($urandom_range(0, 15) == 0)
                    smp = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
                else
                    smp = SAMPLE_W'($urandom_range(0, 1023));
                push_sample(smp, 1'b0, '0);
                burst--;
                sent++;
            end
        end

        sample_ch.valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
